@@ hw/rtl/midi_note_to_fm_register_writer_defines.svh @@
// Assertion macros shared by the note-to-FM register writer checkers
`ifndef MIDI_NOTE_TO_FM_REGISTER_WRITER_DEFINES_SVH
`define MIDI_NOTE_TO_FM_REGISTER_WRITER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define MNFM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define MNFM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/mnfm_pkg.sv @@
// Shared types, constants and tables for the note-to-FM register writer
`default_nettype none

package mnfm_pkg;

	localparam int NUM_CHANNELS = 9;

	localparam int CMD_W   = 2;
	localparam int CH_W    = 4;
	localparam int NOTE_W  = 7;
	localparam int BYTE_W  = 8;
	localparam int MASK_W  = 9;
	localparam int KEY_W   = 5;
	localparam int FNUM_W  = 10;
	localparam int BLOCK_W = 3;
	localparam int QUOT_W  = 4;
	localparam int REM_W   = 4;

	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CNT_W    = $clog2(((NUM_CHANNELS > 2) ? NUM_CHANNELS : 2) + 1);

	localparam logic [BYTE_W-1:0] ADDR_FNUM_LO = 8'hA0;
	localparam logic [BYTE_W-1:0] ADDR_KEY     = 8'hB0;
	localparam logic [BYTE_W-1:0] KEY_ON       = 8'h20;

	localparam logic [NOTE_W-1:0]  DRUM_NOTE  = 7'd60;
	localparam logic [NOTE_W-1:0]  LOW_NOTE   = 7'd12;
	localparam logic [NOTE_W-1:0]  SEMITONES  = 7'd12;
	localparam logic [BLOCK_W-1:0] MAX_BLOCK  = 3'd7;
	localparam int                 MAX_QUOT   = ((1 << NOTE_W) - 1 - 12) / 12;

	typedef enum logic [CMD_W-1:0] {
		CMD_NOTE_ON  = 2'd0,
		CMD_NOTE_OFF = 2'd1,
		CMD_SILENCE  = 2'd2
	} cmd_t;

	// pitch of a note on: low F-number byte and block/F-number high bits
	typedef struct packed {
		logic [BYTE_W-1:0] fnum_lo;
		logic [KEY_W-1:0]  key_bits;
	} pitch_t;

	// everything the write sequencer needs about the held request
	typedef struct packed {
		cmd_t              cmd;
		logic              ch_ok;
		logic [CH_W-1:0]   ch;
		logic [BYTE_W-1:0] fnum_lo;
		logic [KEY_W-1:0]  key_bits;
		logic [KEY_W-1:0]  shadow_key;
	} plan_t;

	// key shadow update, applied when a request finishes
	typedef struct packed {
		logic                wr_en;
		logic                clr_all;
		logic [CH_IDX_W-1:0] idx;
		logic [KEY_W-1:0]    key_bits;
	} shadow_upd_t;

	function automatic logic [FNUM_W-1:0] fnum_lookup(input logic [REM_W-1:0] semi);
		logic [FNUM_W-1:0] f;
		case (semi)
			4'd0:    f = 10'd308;
			4'd1:    f = 10'd325;
			4'd2:    f = 10'd345;
			4'd3:    f = 10'd365;
			4'd4:    f = 10'd387;
			4'd5:    f = 10'd410;
			4'd6:    f = 10'd434;
			4'd7:    f = 10'd460;
			4'd8:    f = 10'd487;
			4'd9:    f = 10'd516;
			4'd10:   f = 10'd547;
			4'd11:   f = 10'd579;
			default: f = 10'd308;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mnfm_if.sv @@
// Request and register-write channel interfaces
`default_nettype none

interface mnfm_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [mnfm_pkg::CMD_W-1:0]      command;
	logic [mnfm_pkg::CH_W-1:0]       channel;
	logic [mnfm_pkg::NOTE_W-1:0]     note;

	modport source (output valid, output command, output channel, output note, input ready);
	modport sink   (input valid, input command, input channel, input note, output ready);
endinterface

interface mnfm_wr_if;
	logic                            valid;
	logic                            ready;
	logic [mnfm_pkg::BYTE_W-1:0]     reg_address;
	logic [mnfm_pkg::BYTE_W-1:0]     reg_data;
	logic                            last;

	modport source (output valid, output reg_address, output reg_data, output last, input ready);
	modport sink   (input valid, input reg_address, input reg_data, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mnfm_pitch.sv @@
// Note number to F-number byte and block/key bits
`default_nettype none

module mnfm_pitch (
	input  wire logic [mnfm_pkg::NOTE_W-1:0] note,
	input  wire logic                        drum,
	output mnfm_pkg::pitch_t                 pitch
);

	logic [mnfm_pkg::NOTE_W-1:0]  note_sel;
	logic [mnfm_pkg::NOTE_W-1:0]  note_clamp;
	logic [mnfm_pkg::NOTE_W-1:0]  semis;
	logic [mnfm_pkg::QUOT_W-1:0]  octave;
	logic [mnfm_pkg::NOTE_W-1:0]  rem;
	logic [mnfm_pkg::BLOCK_W-1:0] block;
	logic [mnfm_pkg::FNUM_W-1:0]  fnum;

	assign note_sel   = drum ? mnfm_pkg::DRUM_NOTE : note;
	assign note_clamp = (note_sel < mnfm_pkg::LOW_NOTE) ? mnfm_pkg::LOW_NOTE : note_sel;
	assign semis      = note_clamp - mnfm_pkg::LOW_NOTE;

	// divide by 12: independent threshold compares, largest hit wins
	always_comb begin
		octave = '0;
		for (int k = 1; k <= mnfm_pkg::MAX_QUOT; k++) begin
			if (semis >= mnfm_pkg::NOTE_W'(12 * k))
				octave = mnfm_pkg::QUOT_W'(k);
		end
	end

	assign rem   = semis - (mnfm_pkg::NOTE_W'(octave) * mnfm_pkg::SEMITONES);
	assign fnum  = mnfm_pkg::fnum_lookup(rem[mnfm_pkg::REM_W-1:0]);
	assign block = (octave > mnfm_pkg::QUOT_W'(mnfm_pkg::MAX_BLOCK)) ?
		mnfm_pkg::MAX_BLOCK : octave[mnfm_pkg::BLOCK_W-1:0];

	always_comb begin
		pitch.fnum_lo  = fnum[mnfm_pkg::BYTE_W-1:0];
		pitch.key_bits = {block, fnum[mnfm_pkg::FNUM_W-1:mnfm_pkg::BYTE_W]};
	end

endmodule

`default_nettype wire

@@ hw/rtl/mnfm_shadow.sv @@
// Per-channel key shadow registers (block and F-number high bits)
`default_nettype none

module mnfm_shadow (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [mnfm_pkg::CH_IDX_W-1:0] rd_idx,
	output logic      [mnfm_pkg::KEY_W-1:0]    rd_key,
	input  wire mnfm_pkg::shadow_upd_t         upd
);

	logic [mnfm_pkg::KEY_W-1:0] shadow_q [mnfm_pkg::NUM_CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mnfm_pkg::NUM_CHANNELS; i++)
				shadow_q[i] <= '0;
		end else if (upd.clr_all) begin
			for (int i = 0; i < mnfm_pkg::NUM_CHANNELS; i++)
				shadow_q[i] <= '0;
		end else if (upd.wr_en) begin
			shadow_q[upd.idx] <= upd.key_bits;
		end
	end

	// only consulted for in-range channels
	assign rd_key = shadow_q[rd_idx];

endmodule

`default_nettype wire

@@ hw/rtl/mnfm_emit.sv @@
// Write sequencer and output register: one register write per cycle while wr is not stalled
`default_nettype none

module mnfm_emit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   item_valid,
	input  wire mnfm_pkg::plan_t plan,
	output logic        item_done,
	mnfm_wr_if.source   wr
);

	logic [mnfm_pkg::CNT_W-1:0]  idx_q;
	logic [mnfm_pkg::CNT_W-1:0]  count;
	logic                        is_last;
	logic                        out_free;
	logic                        emit;
	logic [mnfm_pkg::BYTE_W-1:0] nxt_addr;
	logic [mnfm_pkg::BYTE_W-1:0] nxt_data;

	logic                        out_valid_q;
	logic [mnfm_pkg::BYTE_W-1:0] out_addr_q;
	logic [mnfm_pkg::BYTE_W-1:0] out_data_q;
	logic                        out_last_q;

	// writes this request produces
	always_comb begin
		case (plan.cmd)
			mnfm_pkg::CMD_NOTE_ON:  count = plan.ch_ok ? mnfm_pkg::CNT_W'(2) : '0;
			mnfm_pkg::CMD_NOTE_OFF: count = plan.ch_ok ? mnfm_pkg::CNT_W'(1) : '0;
			mnfm_pkg::CMD_SILENCE:  count = mnfm_pkg::CNT_W'(mnfm_pkg::NUM_CHANNELS);
			default:                count = '0;
		endcase
	end

	assign is_last   = (idx_q == (count - mnfm_pkg::CNT_W'(1)));
	assign out_free  = !out_valid_q || wr.ready;
	assign emit      = item_valid && (count != '0) && out_free;
	assign item_done = item_valid && ((count == '0) || (out_free && is_last));

	always_comb begin
		case (plan.cmd)
			mnfm_pkg::CMD_NOTE_ON: begin
				if (idx_q == '0) begin
					nxt_addr = mnfm_pkg::ADDR_FNUM_LO + mnfm_pkg::BYTE_W'(plan.ch);
					nxt_data = plan.fnum_lo;
				end else begin
					nxt_addr = mnfm_pkg::ADDR_KEY + mnfm_pkg::BYTE_W'(plan.ch);
					nxt_data = mnfm_pkg::KEY_ON | mnfm_pkg::BYTE_W'(plan.key_bits);
				end
			end
			mnfm_pkg::CMD_NOTE_OFF: begin
				nxt_addr = mnfm_pkg::ADDR_KEY + mnfm_pkg::BYTE_W'(plan.ch);
				nxt_data = mnfm_pkg::BYTE_W'(plan.shadow_key);
			end
			mnfm_pkg::CMD_SILENCE: begin
				nxt_addr = mnfm_pkg::ADDR_KEY + mnfm_pkg::BYTE_W'(idx_q);
				nxt_data = '0;
			end
			default: begin
				nxt_addr = mnfm_pkg::ADDR_KEY;
				nxt_data = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				idx_q <= is_last ? '0 : idx_q + mnfm_pkg::CNT_W'(1);
			if (out_free)
				out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_addr_q <= nxt_addr;
			out_data_q <= nxt_data;
			out_last_q <= is_last;
		end
	end

	assign wr.valid       = out_valid_q;
	assign wr.reg_address = out_addr_q;
	assign wr.reg_data    = out_data_q;
	assign wr.last        = out_last_q;

endmodule

`default_nettype wire

@@ hw/rtl/midi_note_to_fm_register_writer.sv @@
// Top level: note requests in, FM chip register writes out
// Path: a request is held in the input register, its writes in the output register.
// Throughput: note on 2 writes, note off 1, silence 9 (one write per cycle while reg_wr is
//   not stalled, set by the single output register), dropped requests none; the next request
//   enters as the last write of the current one is registered.
// Reset (arst_n low, asynchronous): no request held, no write pending, key shadows zero,
//   drum mask zero.
`default_nettype none

module midi_note_to_fm_register_writer (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [mnfm_pkg::MASK_W-1:0]  cfg_wr_data,
	mnfm_cmd_if.sink                          note_cmd,
	mnfm_wr_if.source                         reg_wr
);

	// drum channel mask, to be written only while idle; the block itself does not enforce this
	logic [mnfm_pkg::MASK_W-1:0] drum_mask_q;

	// input register: the request being turned into writes
	logic                         valid_s1;
	mnfm_pkg::cmd_t               cmd_s1;
	logic [mnfm_pkg::CH_W-1:0]    ch_s1;
	logic [mnfm_pkg::NOTE_W-1:0]  note_s1;

	logic                         ch_ok;
	logic [mnfm_pkg::CH_IDX_W-1:0] ch_idx;
	logic                         drum;
	logic                         item_done;
	logic [mnfm_pkg::KEY_W-1:0]   shadow_key;
	mnfm_pkg::pitch_t             pitch;
	mnfm_pkg::plan_t              plan;
	mnfm_pkg::shadow_upd_t        shadow_upd;

	// room for a new request when empty or when the held one finishes now
	assign note_cmd.ready = !valid_s1 || item_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drum_mask_q <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (cfg_wr_en)
				drum_mask_q <= cfg_wr_data;
			if (note_cmd.ready)
				valid_s1 <= note_cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (note_cmd.valid && note_cmd.ready) begin
			cmd_s1  <= mnfm_pkg::cmd_t'(note_cmd.command);
			ch_s1   <= note_cmd.channel;
			note_s1 <= note_cmd.note;
		end
	end

	// channels at or above NUM_CHANNELS make note on / note off do nothing
	assign ch_ok  = (ch_s1 < mnfm_pkg::CH_W'(mnfm_pkg::NUM_CHANNELS));
	assign ch_idx = ch_s1[mnfm_pkg::CH_IDX_W-1:0];
	assign drum   = ch_ok && drum_mask_q[ch_s1];

	mnfm_pitch u_pitch (
		.note  (note_s1),
		.drum  (drum),
		.pitch (pitch)
	);

	// Shadow follows request order: a note off reads it only after every earlier
	// note on has finished and written its entry.
	always_comb begin
		shadow_upd.wr_en    = item_done && (cmd_s1 == mnfm_pkg::CMD_NOTE_ON) && ch_ok;
		shadow_upd.clr_all  = item_done && (cmd_s1 == mnfm_pkg::CMD_SILENCE);
		shadow_upd.idx      = ch_idx;
		shadow_upd.key_bits = pitch.key_bits;
	end

	mnfm_shadow u_shadow (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (ch_idx),
		.rd_key (shadow_key),
		.upd    (shadow_upd)
	);

	always_comb begin
		plan.cmd        = cmd_s1;
		plan.ch_ok      = ch_ok;
		plan.ch         = ch_s1;
		plan.fnum_lo    = pitch.fnum_lo;
		plan.key_bits   = pitch.key_bits;
		plan.shadow_key = shadow_key;
	end

	// sequencer: walks the writes of the held request into the output register
	mnfm_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.plan       (plan),
		.item_done  (item_done),
		.wr         (reg_wr)
	);

endmodule

`default_nettype wire

@@ hw/rtl/mnfm_checker.sv @@
// Port-level checks on the register-write stream, bound to the top level
`default_nettype none
`include "midi_note_to_fm_register_writer_defines.svh"

module mnfm_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [mnfm_pkg::BYTE_W-1:0] out_address,
	input wire logic [mnfm_pkg::BYTE_W-1:0] out_data,
	input wire logic                        out_last
);

	logic in_fnum_range;
	logic in_key_range;

	assign in_fnum_range = (out_address >= mnfm_pkg::ADDR_FNUM_LO) &&
		(out_address < mnfm_pkg::ADDR_FNUM_LO + mnfm_pkg::BYTE_W'(mnfm_pkg::NUM_CHANNELS));
	assign in_key_range  = (out_address >= mnfm_pkg::ADDR_KEY) &&
		(out_address < mnfm_pkg::ADDR_KEY + mnfm_pkg::BYTE_W'(mnfm_pkg::NUM_CHANNELS));

	// stalled write holds
	`MNFM_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_address) && $stable(out_data) && $stable(out_last), "write changed while stalled")
	// only frequency-low and key registers of real channels are written
	`MNFM_ASSERT_NOW(a_addr_range, out_valid, in_fnum_range || in_key_range, "write outside channel registers")
	// frequency-low write never ends a request
	`MNFM_ASSERT_NOW(a_fnum_not_last, out_valid && in_fnum_range, !out_last, "frequency write marked last")
	// frequency-low write is followed at once by the key write of the same channel
	`MNFM_ASSERT_NEXT(a_fnum_then_key, out_valid && out_ready && in_fnum_range, out_valid && (out_address == $past(out_address) + 8'h10), "key write did not follow")
	// nonzero key byte only comes from note on / note off, which end on it
	`MNFM_ASSERT_NOW(a_key_data_last, out_valid && in_key_range && (out_data != 8'h00), out_last, "nonzero key write not last")

endmodule

bind midi_note_to_fm_register_writer mnfm_checker u_mnfm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (reg_wr.valid),
	.out_ready   (reg_wr.ready),
	.out_address (reg_wr.reg_address),
	.out_data    (reg_wr.reg_data),
	.out_last    (reg_wr.last)
);

`default_nettype wire

@@ bench/tb_midi_note_to_fm_register_writer.sv @@
// Self-checking bench for the note request to FM register write converter
`timescale 1ns / 100ps

module tb_midi_note_to_fm_register_writer;

	// Command code 3 is not decoded: the block must drop it silently.
	localparam logic [mnfm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Items per random phase that give at least one write; four phases.
	localparam int PHASE_ITEMS = 80;
	localparam int NUM_PHASES  = 4;

	// Cycles the block may still be busy on a dropped request once the
	// last expected write has come out.
	localparam int SETTLE_CYCLES = 4;

	// F-number for each semitone of an octave, lowest first.
	localparam logic [mnfm_pkg::FNUM_W-1:0] FNUM_BY_SEMITONE [12] = '{
		10'd308, 10'd325, 10'd345, 10'd365, 10'd387, 10'd410,
		10'd434, 10'd460, 10'd487, 10'd516, 10'd547, 10'd579
	};

	// One register write as it leaves the block.
	typedef struct packed {
		logic [mnfm_pkg::BYTE_W-1:0] addr;
		logic [mnfm_pkg::BYTE_W-1:0] data;
		logic                        last;
	} fm_write_t;

	// One request. Where typed is set the writes are given by hand (n_typed
	// of them, last set on the final one) instead of coming from the
	// predictor; set_mask loads a new drum mask before the request.
	typedef struct packed {
		logic                        set_mask;
		logic [mnfm_pkg::MASK_W-1:0] mask;
		logic [mnfm_pkg::CMD_W-1:0]  cmd;
		logic [mnfm_pkg::CH_W-1:0]   ch;
		logic [mnfm_pkg::NOTE_W-1:0] note;
		logic                        typed;
		logic [1:0]                  n_typed;
		logic [mnfm_pkg::BYTE_W-1:0] a0;
		logic [mnfm_pkg::BYTE_W-1:0] d0;
		logic [mnfm_pkg::BYTE_W-1:0] a1;
		logic [mnfm_pkg::BYTE_W-1:0] d1;
	} stim_row_t;

	// Directed requests: bounds of every field, every command, clamping of
	// low notes, the octave cap, out-of-range channels, the unused command,
	// silence, and a drum channel.
	stim_row_t directed_rows [25] = '{
		// note off straight after reset: shadow still zero
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_OFF, 4'd0, 7'd0, 1'b1, 2'd1, 8'hB0, 8'h00, 8'h00, 8'h00},
		// lowest note clamps to 12: block 0, F-number 308
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_ON, 4'd0, 7'd0, 1'b1, 2'd2, 8'hA0, 8'h34, 8'hB0, 8'h21},
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_OFF, 4'd0, 7'd0, 1'b1, 2'd1, 8'hB0, 8'h01, 8'h00, 8'h00},
		// highest note on the top channel: block capped at 7, F-number 460
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_ON, 4'd8, 7'd127, 1'b1, 2'd2, 8'hA8, 8'hCC, 8'hB8, 8'h3D},
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_OFF, 4'd8, 7'd0, 1'b1, 2'd1, 8'hB8, 8'h1D, 8'h00, 8'h00},
		// out-of-range channels and the unused command give nothing
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_ON, 4'd9, 7'd60, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_OFF, 4'd15, 7'd0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{1'b0, 9'h000, CMD_UNUSED, 4'd0, 7'd0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00},
		// octave and semitone boundaries
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_ON, 4'd4, 7'd11, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_ON, 4'd1, 7'd12, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_ON, 4'd2, 7'd23, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_ON, 4'd3, 7'd24, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_ON, 4'd5, 7'd60, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_ON, 4'd6, 7'd95, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_ON, 4'd7, 7'd96, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_ON, 4'd4, 7'd107, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_ON, 4'd5, 7'd108, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_OFF, 4'd5, 7'd0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00},
		// silence ignores channel and note, then every shadow reads zero
		'{1'b0, 9'h000, mnfm_pkg::CMD_SILENCE, 4'd15, 7'd127, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_OFF, 4'd6, 7'd0, 1'b1, 2'd1, 8'hB6, 8'h00, 8'h00, 8'h00},
		'{1'b0, 9'h000, CMD_UNUSED, 4'd15, 7'd127, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00},
		// drum on channel 0: any note plays as 60 (block 4, F-number 308)
		'{1'b1, 9'h001, mnfm_pkg::CMD_NOTE_ON, 4'd0, 7'd0, 1'b1, 2'd2, 8'hA0, 8'h34, 8'hB0, 8'h31},
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_ON, 4'd1, 7'd0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{1'b0, 9'h000, mnfm_pkg::CMD_NOTE_OFF, 4'd0, 7'd0, 1'b1, 2'd1, 8'hB0, 8'h11, 8'h00, 8'h00},
		'{1'b0, 9'h000, mnfm_pkg::CMD_SILENCE, 4'd0, 7'd0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_wr_en;
	logic [mnfm_pkg::MASK_W-1:0] cfg_wr_data;

	mnfm_cmd_if note_cmd_bus ();
	mnfm_wr_if  reg_wr_bus ();

	midi_note_to_fm_register_writer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.note_cmd    (note_cmd_bus.sink),
		.reg_wr      (reg_wr_bus.source)
	);

	// Mirror of the block's state as seen by the predictor.
	logic [mnfm_pkg::KEY_W-1:0]  voice_key_bits [mnfm_pkg::NUM_CHANNELS];
	logic [mnfm_pkg::MASK_W-1:0] drum_voices;

	fm_write_t request_writes [$];  // writes of the request just accepted
	fm_write_t writes_due [$];      // writes still to come out, oldest first
	int        fail_count = 0;
	bit        idle_on = 1'b1;      // random gaps on both sides when set

	always #2 clk = ~clk;

	// Writes caused by one request; updates the mirrored key shadows.
	function automatic void fm_writes_for_request(input logic [mnfm_pkg::CMD_W-1:0] cmd_code,
			input logic [mnfm_pkg::CH_W-1:0] chan,
			input logic [mnfm_pkg::NOTE_W-1:0] note_num);
		int                          pitch;
		int                          octave;
		logic [mnfm_pkg::FNUM_W-1:0] fnum;
		logic [mnfm_pkg::KEY_W-1:0]  key_bits;
		request_writes.delete();
		if (cmd_code == mnfm_pkg::CMD_SILENCE) begin
			for (int v = 0; v < mnfm_pkg::NUM_CHANNELS; v++) begin
				request_writes.push_back(fm_write_t'{
					mnfm_pkg::ADDR_KEY + mnfm_pkg::BYTE_W'(v), 8'h00,
					v == mnfm_pkg::NUM_CHANNELS - 1});
				voice_key_bits[v] = '0;
			end
		end else if (cmd_code == mnfm_pkg::CMD_NOTE_ON && chan < mnfm_pkg::NUM_CHANNELS) begin
			pitch = drum_voices[chan] ? int'(mnfm_pkg::DRUM_NOTE) : int'(note_num);
			if (pitch < mnfm_pkg::LOW_NOTE)
				pitch = mnfm_pkg::LOW_NOTE;
			octave = (pitch - mnfm_pkg::LOW_NOTE) / mnfm_pkg::SEMITONES;
			if (octave > mnfm_pkg::MAX_BLOCK)
				octave = mnfm_pkg::MAX_BLOCK;
			fnum = FNUM_BY_SEMITONE[(pitch - mnfm_pkg::LOW_NOTE) % mnfm_pkg::SEMITONES];
			key_bits = {octave[mnfm_pkg::BLOCK_W-1:0],
				fnum[mnfm_pkg::FNUM_W-1:mnfm_pkg::BYTE_W]};
			request_writes.push_back(fm_write_t'{
				mnfm_pkg::ADDR_FNUM_LO + mnfm_pkg::BYTE_W'(chan),
				fnum[mnfm_pkg::BYTE_W-1:0], 1'b0});
			request_writes.push_back(fm_write_t'{
				mnfm_pkg::ADDR_KEY + mnfm_pkg::BYTE_W'(chan),
				mnfm_pkg::KEY_ON | {3'b000, key_bits}, 1'b1});
			voice_key_bits[chan] = key_bits;
		end else if (cmd_code == mnfm_pkg::CMD_NOTE_OFF && chan < mnfm_pkg::NUM_CHANNELS) begin
			request_writes.push_back(fm_write_t'{
				mnfm_pkg::ADDR_KEY + mnfm_pkg::BYTE_W'(chan),
				{3'b000, voice_key_bits[chan]}, 1'b1});
		end
	endfunction

	// Present one request from a falling edge, hold it until accepted, queue
	// its writes at the accepting edge and return at the next falling edge.
	task automatic send_request(input stim_row_t row, output int n_writes);
		while (idle_on && $urandom_range(99) < 9) begin
			note_cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		note_cmd_bus.valid   <= 1'b1;
		note_cmd_bus.command <= row.cmd;
		note_cmd_bus.channel <= row.ch;
		note_cmd_bus.note    <= row.note;
		@(posedge clk);
		while (!note_cmd_bus.ready)
			@(posedge clk);
		// accepted at this edge: the first write appears once it has passed the output register
		fm_writes_for_request(row.cmd, row.ch, row.note);
		if (!row.typed) begin
			n_writes = request_writes.size();
			foreach (request_writes[i])
				writes_due.push_back(request_writes[i]);
		end else begin
			n_writes = row.n_typed;
			if (row.n_typed == 1)
				writes_due.push_back(fm_write_t'{row.a0, row.d0, 1'b1});
			if (row.n_typed == 2) begin
				writes_due.push_back(fm_write_t'{row.a0, row.d0, 1'b0});
				writes_due.push_back(fm_write_t'{row.a1, row.d1, 1'b1});
			end
		end
		@(negedge clk);
	endtask

	// Drop valid, let every queued write drain, then allow the block time to
	// finish any dropped request still in flight.
	task automatic settle();
		note_cmd_bus.valid <= 1'b0;
		while (writes_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Load the drum mask while the block is idle; the mirror follows.
	task automatic write_drum_mask(input logic [mnfm_pkg::MASK_W-1:0] mask);
		cfg_wr_data <= mask;
		cfg_wr_en   <= 1'b1;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		drum_voices = mask;
	endtask

	// Random request: mostly well-formed note traffic on live channels,
	// the rest silence, out-of-range channels and the unused command.
	function automatic stim_row_t random_request();
		stim_row_t row;
		int        pick;
		row = '0;
		pick = $urandom_range(99);
		row.note = mnfm_pkg::NOTE_W'($urandom_range((1 << mnfm_pkg::NOTE_W) - 1));
		row.ch   = mnfm_pkg::CH_W'($urandom_range(mnfm_pkg::NUM_CHANNELS - 1));
		if (pick < 45) begin
			row.cmd = mnfm_pkg::CMD_NOTE_ON;
		end else if (pick < 75) begin
			row.cmd = mnfm_pkg::CMD_NOTE_OFF;
		end else if (pick < 83) begin
			row.cmd = mnfm_pkg::CMD_SILENCE;
			row.ch  = mnfm_pkg::CH_W'($urandom_range((1 << mnfm_pkg::CH_W) - 1));
		end else if (pick < 92) begin
			row.cmd = $urandom_range(1) ? mnfm_pkg::CMD_NOTE_ON : mnfm_pkg::CMD_NOTE_OFF;
			row.ch  = mnfm_pkg::CH_W'($urandom_range((1 << mnfm_pkg::CH_W) - 1,
				mnfm_pkg::NUM_CHANNELS));
		end else begin
			row.cmd = CMD_UNUSED;
			row.ch  = mnfm_pkg::CH_W'($urandom_range((1 << mnfm_pkg::CH_W) - 1));
		end
		return row;
	endfunction

	// Write side: random back-pressure, changed on the falling edge.
	initial begin : write_sink
		reg_wr_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			reg_wr_bus.ready <= !(idle_on && $urandom_range(99) < 9);
		end
	end

	// Every write taken at a rising edge is matched against the oldest one due.
	always @(posedge clk) begin : check_writes
		fm_write_t due;
		if (arst_n && reg_wr_bus.valid && reg_wr_bus.ready) begin
			if (writes_due.size() == 0) begin
				$error("unexpected write: reg_address 0x%02h reg_data 0x%02h last %0b",
					reg_wr_bus.reg_address, reg_wr_bus.reg_data, reg_wr_bus.last);
				fail_count++;
			end else begin
				due = writes_due.pop_front();
				if (reg_wr_bus.reg_address !== due.addr) begin
					$error("reg_address: expected 0x%02h, got 0x%02h",
						due.addr, reg_wr_bus.reg_address);
					fail_count++;
				end
				if (reg_wr_bus.reg_data !== due.data) begin
					$error("reg_data: expected 0x%02h, got 0x%02h",
						due.data, reg_wr_bus.reg_data);
					fail_count++;
				end
				if (reg_wr_bus.last !== due.last) begin
					$error("last: expected %0b, got %0b", due.last, reg_wr_bus.last);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		stim_row_t                   row;
		int                          n_writes;
		int                          productive;
		logic [mnfm_pkg::MASK_W-1:0] phase_mask [NUM_PHASES];

		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_wr_data          = '0;
		note_cmd_bus.valid   = 1'b0;
		note_cmd_bus.command = '0;
		note_cmd_bus.channel = '0;
		note_cmd_bus.note    = '0;
		drum_voices          = '0;
		foreach (voice_key_bits[v])
			voice_key_bits[v] = '0;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].set_mask) begin
				settle();
				write_drum_mask(directed_rows[i].mask);
			end
			send_request(directed_rows[i], n_writes);
		end

		// random phases: all drums, random, no drums (and no gaps), random
		phase_mask[0] = '1;
		phase_mask[1] = mnfm_pkg::MASK_W'($urandom_range((1 << mnfm_pkg::MASK_W) - 1));
		phase_mask[2] = '0;
		phase_mask[3] = mnfm_pkg::MASK_W'($urandom_range((1 << mnfm_pkg::MASK_W) - 1));
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			write_drum_mask(phase_mask[p]);
			idle_on <= (p != 2);
			productive = 0;
			while (productive < PHASE_ITEMS) begin
				// in the second phase the sender holds off mid-phase until every write has drained
				if (p == 1 && productive == PHASE_ITEMS / 2)
					settle();
				row = random_request();
				send_request(row, n_writes);
				if (n_writes > 0)
					productive++;
			end
		end

		settle();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && writes_due.size() == 0)
			$display("tb_midi_note_to_fm_register_writer: PASS");
		else
			$display("tb_midi_note_to_fm_register_writer: FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#2ms;
		$display("tb_midi_note_to_fm_register_writer: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/mnfm_pkg.sv
hw/rtl/mnfm_if.sv
hw/rtl/mnfm_pitch.sv
hw/rtl/mnfm_shadow.sv
hw/rtl/mnfm_emit.sv
hw/rtl/midi_note_to_fm_register_writer.sv
hw/rtl/mnfm_checker.sv
bench/tb_midi_note_to_fm_register_writer.sv
